// ----- src/stereo_disparity_triangulation_defines.svh -----
// Assertion helpers for the stereo triangulation block
`ifndef STEREO_DISPARITY_TRIANGULATION_DEFINES_SVH
`define STEREO_DISPARITY_TRIANGULATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define STDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define STDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/stdt_pkg.sv -----
package stdt_pkg;

    // Field widths
    localparam int COORD_W     = 16;
    localparam int PARAM_W     = 32;
    localparam int FRAC_SHIFT  = 4;
    localparam int QUOT_W      = PARAM_W + FRAC_SHIFT;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FOCAL_BASELINE   = 8'd0,
        REG_INVERSE_FOCAL    = 8'd1,
        REG_PRINCIPAL_COLUMN = 8'd2,
        REG_PRINCIPAL_ROW    = 8'd3
    } cfg_reg_t;

    // Payload carried down the divider chain
    typedef struct packed {
        logic               pos;
        logic [QUOT_W-1:0]  acc;
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] den;
        logic [COORD_W-1:0] mag_x;
        logic               neg_x;
        logic [COORD_W-1:0] mag_y;
        logic               neg_y;
    } div_lane_t;

endpackage

// ----- src/stdt_div_cell.sv -----
module stdt_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              v_in,
    input  stdt_pkg::div_lane_t lane_in,
    output logic              v_out,
    output stdt_pkg::div_lane_t lane_out
);
    import stdt_pkg::*;

    logic [COORD_W:0] rem_shift;
    logic             take;
    div_lane_t        lane_next;
    div_lane_t        lane_reg;
    logic             v_reg;

    // Bring down the next dividend bit, subtract when the divisor fits
    always_comb
    begin
        rem_shift = {lane_in.rem, lane_in.acc[QUOT_W-1]};
        take      = (rem_shift >= {1'b0, lane_in.den});
        lane_next = lane_in;
        if (take)
        begin
            lane_next.rem = COORD_W'(rem_shift - {1'b0, lane_in.den});
        end
        else
        begin
            lane_next.rem = rem_shift[COORD_W-1:0];
        end
        lane_next.acc = {lane_in.acc[QUOT_W-2:0], take};
    end

    // Advance the valid flag with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    // Advance the payload with the chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg <= lane_next;
        end
    end

    assign v_out    = v_reg;
    assign lane_out = lane_reg;

endmodule

// ----- src/stdt_coord.sv -----
module stdt_coord (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [stdt_pkg::QUOT_W-1:0]   zfull,
    input  logic [stdt_pkg::COORD_W-1:0]  mag,
    input  logic                          neg,
    input  logic [stdt_pkg::PARAM_W-1:0]  inv,
    output logic [stdt_pkg::PARAM_W-1:0]  coord
);
    import stdt_pkg::*;

    localparam int PROD_W = COORD_W + QUOT_W;
    localparam int HIGH_W = PROD_W - PARAM_W;
    localparam int SUM_W  = PARAM_W + HIGH_W + 1;

    logic [COORD_W+PARAM_W-1:0]  lo_prod;
    logic [HIGH_W-1:0]           hi_prod;
    logic [PROD_W-1:0]           p_next;
    logic [PROD_W-1:0]           p_reg;
    logic                        neg_a_reg;

    logic [2*PARAM_W-1:0]        t_next;
    logic [PARAM_W+HIGH_W-1:0]   u_next;
    logic [2*PARAM_W-1:0]        t_reg;
    logic [PARAM_W+HIGH_W-1:0]   u_reg;
    logic                        neg_b_reg;

    logic [SUM_W-1:0]            s_sum;
    logic [SUM_W-FRAC_SHIFT-1:0] m_mag;
    logic [PARAM_W-1:0]          coord_next;
    logic [PARAM_W-1:0]          coord_reg;

    // Offset magnitude times depth, split at bit 32 of the depth
    always_comb
    begin
        lo_prod = mag * zfull[PARAM_W-1:0];
        hi_prod = HIGH_W'(mag) * HIGH_W'(zfull[QUOT_W-1:PARAM_W]);
        p_next  = PROD_W'(lo_prod) + {hi_prod, {PARAM_W{1'b0}}};
    end

    // Scale by the inverse focal length in two partial products
    always_comb
    begin
        t_next = inv * p_reg[PARAM_W-1:0];
        u_next = inv * p_reg[PROD_W-1:PARAM_W];
    end

    // Combine partial products, drop the fraction, apply sign and saturate
    always_comb
    begin
        s_sum = SUM_W'(u_reg) + SUM_W'(t_reg[2*PARAM_W-1:PARAM_W]);
        m_mag = s_sum[SUM_W-1:FRAC_SHIFT];
        if (!neg_b_reg)
        begin
            if (m_mag > (SUM_W-FRAC_SHIFT)'(32'h7FFF_FFFF))
            begin
                coord_next = 32'h7FFF_FFFF;
            end
            else
            begin
                coord_next = m_mag[PARAM_W-1:0];
            end
        end
        else
        begin
            if (m_mag > (SUM_W-FRAC_SHIFT)'(32'h8000_0000))
            begin
                coord_next = 32'h8000_0000;
            end
            else
            begin
                coord_next = PARAM_W'(0) - m_mag[PARAM_W-1:0];
            end
        end
    end

    // Three product stages, all held while the output is stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg     <= p_next;
            neg_a_reg <= neg;
            t_reg     <= t_next;
            u_reg     <= u_next;
            neg_b_reg <= neg_a_reg;
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

// ----- src/stereo_disparity_triangulation.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | left_column, left_row, right_column
// out      | out_valid / out_stall| point_x, point_y, point_z, point_valid
// cfg      | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; 36 divider cells, one
// quotient bit each, then three multiply stages for the coordinates.
// Reset clears the valid flags and the configuration registers to zero.
// A stalled output freezes the whole chain; a one-entry skid buffer on the
// input keeps in_stall a register output.
`include "stereo_disparity_triangulation_defines.svh"

module stereo_disparity_triangulation (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [stdt_pkg::COORD_W-1:0]       left_column,
    input  logic [stdt_pkg::COORD_W-1:0]       left_row,
    input  logic [stdt_pkg::COORD_W-1:0]       right_column,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [stdt_pkg::PARAM_W-1:0] point_x,
    output logic signed [stdt_pkg::PARAM_W-1:0] point_y,
    output logic [stdt_pkg::PARAM_W-1:0]       point_z,
    output logic                               point_valid,
    input  logic                               cfg_we,
    input  logic [stdt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [stdt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import stdt_pkg::*;

    // Configuration registers
    logic [PARAM_W-1:0] focal_baseline_reg;
    logic [PARAM_W-1:0] inverse_focal_reg;
    logic [COORD_W-1:0] principal_column_reg;
    logic [COORD_W-1:0] principal_row_reg;

    // Input skid buffer
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [COORD_W-1:0] skid_lc_reg;
    logic [COORD_W-1:0] skid_lr_reg;
    logic [COORD_W-1:0] skid_rc_reg;
    logic               accept_in;

    // Front of the chain
    logic               adv;
    logic               front_v;
    logic [COORD_W-1:0] front_lc;
    logic [COORD_W-1:0] front_lr;
    logic [COORD_W-1:0] front_rc;

    // Divider chain
    div_lane_t          lane [0:DIV_STEPS];
    logic [DIV_STEPS:0] lane_v;

    // Multiply stages alongside the coordinate units
    logic               v_a_reg;
    logic               v_b_reg;
    logic               v_c_reg;
    logic               pos_a_reg;
    logic               pos_b_reg;
    logic               pos_c_reg;
    logic [PARAM_W-1:0] z_a_next;
    logic [PARAM_W-1:0] z_a_reg;
    logic [PARAM_W-1:0] z_b_reg;
    logic [PARAM_W-1:0] z_c_reg;
    logic [PARAM_W-1:0] x_coord;
    logic [PARAM_W-1:0] y_coord;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_baseline_reg   <= '0;
            inverse_focal_reg    <= '0;
            principal_column_reg <= '0;
            principal_row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FOCAL_BASELINE:   focal_baseline_reg   <= cfg_data[PARAM_W-1:0];
                REG_INVERSE_FOCAL:    inverse_focal_reg    <= cfg_data[PARAM_W-1:0];
                REG_PRINCIPAL_COLUMN: principal_column_reg <= cfg_data[COORD_W-1:0];
                REG_PRINCIPAL_ROW:    principal_row_reg    <= cfg_data[COORD_W-1:0];
                default:              ;
            endcase
        end
    end

    // Advance the chain whenever the output register can move
    assign adv       = !v_c_reg || !out_stall;
    assign in_stall  = skid_valid_reg;
    assign accept_in = in_valid && !skid_valid_reg;

    // Select the front transaction: the skid entry first, else the port
    always_comb
    begin
        front_v  = skid_valid_reg || in_valid;
        front_lc = skid_valid_reg ? skid_lc_reg : left_column;
        front_lr = skid_valid_reg ? skid_lr_reg : left_row;
        front_rc = skid_valid_reg ? skid_rc_reg : right_column;
    end

    // Fill the skid when the chain is held, drain it when the chain moves
    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (adv)
        begin
            skid_valid_next = 1'b0;
        end
        else if (accept_in)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in && !adv)
        begin
            skid_lc_reg <= left_column;
            skid_lr_reg <= left_row;
            skid_rc_reg <= right_column;
        end
    end

    // Form disparity, dividend and principal-point offsets
    always_comb
    begin
        lane_v[0]     = front_v;
        lane[0].pos   = (front_lc > front_rc);
        lane[0].acc   = {focal_baseline_reg, {FRAC_SHIFT{1'b0}}};
        lane[0].rem   = '0;
        lane[0].den   = front_lc - front_rc;
        lane[0].neg_x = (front_lc < principal_column_reg);
        lane[0].mag_x = lane[0].neg_x ? principal_column_reg - front_lc
                                      : front_lc - principal_column_reg;
        lane[0].neg_y = (front_lr < principal_row_reg);
        lane[0].mag_y = lane[0].neg_y ? principal_row_reg - front_lr
                                      : front_lr - principal_row_reg;
    end

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        stdt_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .v_in     (lane_v[i]),
            .lane_in  (lane[i]),
            .v_out    (lane_v[i+1]),
            .lane_out (lane[i+1])
        );
    end

    // Lateral and vertical coordinates
    stdt_coord u_coord_x (
        .clk   (clk),
        .adv   (adv),
        .zfull (lane[DIV_STEPS].acc),
        .mag   (lane[DIV_STEPS].mag_x),
        .neg   (lane[DIV_STEPS].neg_x),
        .inv   (inverse_focal_reg),
        .coord (x_coord)
    );

    stdt_coord u_coord_y (
        .clk   (clk),
        .adv   (adv),
        .zfull (lane[DIV_STEPS].acc),
        .mag   (lane[DIV_STEPS].mag_y),
        .neg   (lane[DIV_STEPS].neg_y),
        .inv   (inverse_focal_reg),
        .coord (y_coord)
    );

    // Saturate depth to 32 bits
    assign z_a_next = (|lane[DIV_STEPS].acc[QUOT_W-1:PARAM_W]) ? '1
                                                              : lane[DIV_STEPS].acc[PARAM_W-1:0];

    // Carry valid flags alongside the multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_a_reg <= lane_v[DIV_STEPS];
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
        end
    end

    // Carry depth and disparity sign alongside the multiply stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_a_reg <= lane[DIV_STEPS].pos;
            pos_b_reg <= pos_a_reg;
            pos_c_reg <= pos_b_reg;
            z_a_reg   <= z_a_next;
            z_b_reg   <= z_a_reg;
            z_c_reg   <= z_b_reg;
        end
    end

    // Drive the result, zeroed when the disparity is not positive
    assign out_valid   = v_c_reg;
    assign point_valid = pos_c_reg;
    assign point_x     = pos_c_reg ? x_coord : '0;
    assign point_y     = pos_c_reg ? y_coord : '0;
    assign point_z     = pos_c_reg ? z_c_reg : '0;

    // Checks
    `STDT_ASSERT_SAME(a_invalid_zero, out_valid && !point_valid,
        point_x == '0 && point_y == '0 && point_z == '0,
        "invalid point carries nonzero coordinates")
    `STDT_ASSERT_SAME(a_skid_only_on_hold, skid_valid_reg, $past(!adv),
        "skid entry present without a held chain")
    `STDT_ASSERT_NEXT(a_output_drains, out_valid && !out_stall && !v_b_reg, !out_valid,
        "output still valid after draining an empty stage")

endmodule
